[hw/rtl/bpp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared types, constants and helpers for the bitplane to palette pixel block.
// ----------------------------------------------------------------------------
package bpp_pkg;

	// palette geometry
	localparam int PAL_ENTRIES = 256;
	localparam int PAL_AW      = $clog2(PAL_ENTRIES);

	// field widths
	localparam int PLANE_W     = 16;
	localparam int MAX_PLANES  = 8;
	localparam int STORE_DEPTH = MAX_PLANES - 1;
	localparam int COLOR_W     = 24;
	localparam int IDX_W       = 8;

	// plane mode codes
	localparam logic [1:0] MODE_MONO   = 2'd0;
	localparam logic [1:0] MODE_TWO    = 2'd1;
	localparam logic [1:0] MODE_FOUR   = 2'd2;
	localparam logic [1:0] MODE_EIGHT  = 2'd3;

	// register indexes, taken from paddr[2]
	localparam logic REG_PLANE_MODE  = 1'b0;
	localparam logic REG_LINE_GROUPS = 1'b1;

	// register reset values
	localparam logic [1:0] PLANE_MODE_RST  = MODE_TWO;
	localparam logic [6:0] LINE_GROUPS_RST = 7'd80;

	// item function codes
	localparam logic FUNC_PLANE   = 1'b0;
	localparam logic FUNC_PALETTE = 1'b1;

	// mono colours
	localparam logic [COLOR_W-1:0] RGB_WHITE = 24'hffffff;
	localparam logic [COLOR_W-1:0] RGB_BLACK = 24'h000000;

	typedef struct packed {
		logic               func;
		logic [PLANE_W-1:0] plane_word;
		logic [IDX_W-1:0]   palette_index;
		logic [COLOR_W-1:0] palette_color;
	} in_item_t;

	typedef struct packed {
		logic [COLOR_W-1:0] pixel_color;
		logic               last_of_group;
		logic               last_of_line;
	} out_item_t;

	// completed group handed to the pixel sequencer
	typedef struct packed {
		logic                               load;
		logic [MAX_PLANES-1:0][PLANE_W-1:0] words;
		logic                               mono;
		logic                               line_end;
	} grp_t;

	// palette entry write
	typedef struct packed {
		logic               en;
		logic [PAL_AW-1:0]  addr;
		logic [COLOR_W-1:0] color;
	} pal_wr_t;

	function automatic logic pal_in_range(input logic [IDX_W-1:0] idx);
		return 32'(idx) < PAL_ENTRIES;
	endfunction

endpackage

[hw/rtl/bpp_gather.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_gather
// Input side: buffers plane words until a group is complete, tracks the
// line position and passes palette writes through.
// ----------------------------------------------------------------------------
module bpp_gather (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bpp_pkg::in_item_t in_item,
	input  logic [1:0]        plane_mode,
	input  logic [6:0]        line_groups,
	input  logic              mode_wr,
	input  logic              busy,
	output bpp_pkg::grp_t     grp,
	output bpp_pkg::pal_wr_t  pal_wr
);
	import bpp_pkg::*;

	logic [2:0]         plane_count_q;
	logic [6:0]         group_count_q;
	logic [PLANE_W-1:0] store_q [STORE_DEPTH];
	logic [2:0]         planes_m1;
	logic               completes;
	logic               accept;
	logic               line_end;

	// number of planes minus one for the current mode
	always_comb begin
		case (plane_mode)
			MODE_MONO:  planes_m1 = 3'd0;
			MODE_TWO:   planes_m1 = 3'd1;
			MODE_FOUR:  planes_m1 = 3'd3;
			MODE_EIGHT: planes_m1 = 3'd7;
			default:    planes_m1 = 3'd0;
		endcase
	end

	assign completes = (plane_count_q >= planes_m1);
	assign line_end  = ({1'b0, group_count_q} + 8'd1) >= {1'b0, line_groups};

	// palette writes and group-completing words wait for the sequencer
	assign in_ready = !busy || ((in_item.func == FUNC_PLANE) && !completes);
	assign accept   = in_valid && in_ready;

	// assemble the completed group, unused planes read as zero
	always_comb begin
		grp.load     = accept && (in_item.func == FUNC_PLANE) && completes;
		grp.mono     = (plane_mode == MODE_MONO);
		grp.line_end = line_end;
		grp.words    = '0;
		for (int k = 0; k < STORE_DEPTH; k++) begin
			if (3'(k) < planes_m1) begin
				grp.words[k] = store_q[k];
			end
		end
		grp.words[planes_m1] = in_item.plane_word;
	end

	// palette entry write request
	always_comb begin
		pal_wr.en    = accept && (in_item.func == FUNC_PALETTE)
		               && pal_in_range(in_item.palette_index);
		pal_wr.addr  = in_item.palette_index[PAL_AW-1:0];
		pal_wr.color = in_item.palette_color;
	end

	// plane word store
	always_ff @(posedge clk) begin
		if (accept && (in_item.func == FUNC_PLANE) && !completes) begin
			store_q[plane_count_q] <= in_item.plane_word;
		end
	end

	// plane and group counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_count_q <= '0;
			group_count_q <= '0;
		end else if (mode_wr) begin
			plane_count_q <= '0;
		end else if (accept && (in_item.func == FUNC_PLANE)) begin
			if (completes) begin
				plane_count_q <= '0;
				group_count_q <= line_end ? 7'd0 : group_count_q + 7'd1;
			end else begin
				plane_count_q <= plane_count_q + 3'd1;
			end
		end
	end

endmodule

[hw/rtl/bpp_pixel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_pixel
// Pixel sequencer: walks the sixteen pixels of a group, looks each index up
// in the palette memory and drives the output register.
// ----------------------------------------------------------------------------
module bpp_pixel (
	input  logic               clk,
	input  logic               arst_n,
	input  bpp_pkg::grp_t      grp,
	input  bpp_pkg::pal_wr_t   pal_wr,
	output logic               busy,
	output logic               out_valid,
	input  logic               out_ready,
	output bpp_pkg::out_item_t out_item
);
	import bpp_pkg::*;

	logic [COLOR_W-1:0] pal_mem [PAL_ENTRIES];

	grp_t               grp_q;
	logic               active_q;
	logic [3:0]         pix_cnt_q;
	logic [3:0]         bit_sel;
	logic [IDX_W-1:0]   pix_idx;
	logic               adv_s1;
	logic               adv_s2;

	logic               valid_s1;
	logic               mono_s1;
	logic               bit_s1;
	logic               oob_s1;
	logic               last_g_s1;
	logic               last_l_s1;
	logic [COLOR_W-1:0] rd_s1;

	logic               out_valid_q;
	out_item_t          out_item_q;
	logic [COLOR_W-1:0] color;

	// free as soon as the last pixel of the group moves on
	assign busy = active_q && !(adv_s1 && (pix_cnt_q == 4'd15));

	// bits 7..0 first, then 15..8
	assign bit_sel = {pix_cnt_q[3], ~pix_cnt_q[2:0]};

	always_comb begin
		for (int k = 0; k < MAX_PLANES; k++) begin
			pix_idx[k] = grp_q.words[k][bit_sel];
		end
	end

	assign adv_s2 = !out_valid_q || out_ready;
	assign adv_s1 = !valid_s1 || adv_s2;

	// group register and pixel counter
	always_ff @(posedge clk) begin
		if (grp.load) begin
			grp_q <= grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			pix_cnt_q <= '0;
		end else if (grp.load) begin
			active_q  <= 1'b1;
			pix_cnt_q <= '0;
		end else if (active_q && adv_s1) begin
			pix_cnt_q <= pix_cnt_q + 4'd1;
			if (pix_cnt_q == 4'd15) begin
				active_q <= 1'b0;
			end
		end
	end

	// palette memory
	always_ff @(posedge clk) begin
		if (pal_wr.en) begin
			pal_mem[pal_wr.addr] <= pal_wr.color;
		end
		if (active_q && adv_s1) begin
			rd_s1 <= pal_mem[pix_idx[PAL_AW-1:0]];
		end
	end

	// lookup stage sideband
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			mono_s1   <= grp_q.mono;
			bit_s1    <= pix_idx[0];
			oob_s1    <= !pal_in_range(pix_idx);
			last_g_s1 <= (pix_cnt_q == 4'd15);
			last_l_s1 <= (pix_cnt_q == 4'd15) && grp_q.line_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= active_q;
		end
	end

	// colour select
	always_comb begin
		if (mono_s1) begin
			color = bit_s1 ? RGB_BLACK : RGB_WHITE;
		end else if (oob_s1) begin
			color = '0;
		end else begin
			color = rd_s1;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			out_item_q.pixel_color   <= color;
			out_item_q.last_of_group <= last_g_s1;
			out_item_q.last_of_line  <= last_l_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s2) begin
			out_valid_q <= valid_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

[hw/rtl/bitplane_to_palette_pixels.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitplane_to_palette_pixels
// Converts interleaved bitplane words into r8g8b8 pixels through a palette.
//
//   channel   direction  handshake                  payload
//   in        input      in_valid / in_ready        in_item   (in_item_t)
//   out       output     out_valid / out_ready      out_item  (out_item_t)
//   config    input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A group of 1, 2, 4 or 8 plane words yields 16 pixels, one per cycle unless
// the output stalls. Other plane words are taken also during a group;
// palette writes and group-completing words wait for the sequencer's last
// pixel. Sequenced pixels pass the lookup register and the output register.
// No palette clearing after reset; a stalled output holds it all.
// ----------------------------------------------------------------------------
module bitplane_to_palette_pixels (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bpp_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output bpp_pkg::out_item_t out_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import bpp_pkg::*;

	logic [1:0] plane_mode_q;
	logic [6:0] line_groups_q;
	logic       cfg_wr;
	logic       mode_wr;
	logic       busy;
	grp_t       grp;
	pal_wr_t    pal_wr;

	// register file
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign mode_wr = cfg_wr && (paddr[2] == REG_PLANE_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_mode_q  <= PLANE_MODE_RST;
			line_groups_q <= LINE_GROUPS_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_PLANE_MODE) begin
				plane_mode_q <= pwdata[1:0];
			end else begin
				line_groups_q <= pwdata[6:0];
			end
		end
	end

	// register read
	always_comb begin
		if (paddr[2] == REG_LINE_GROUPS) begin
			prdata = {25'd0, line_groups_q};
		end else begin
			prdata = {30'd0, plane_mode_q};
		end
	end

	bpp_gather u_gather (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.plane_mode  (plane_mode_q),
		.line_groups (line_groups_q),
		.mode_wr     (mode_wr),
		.busy        (busy),
		.grp         (grp),
		.pal_wr      (pal_wr)
	);

	bpp_pixel u_pixel (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp       (grp),
		.pal_wr    (pal_wr),
		.busy      (busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

[hw/rtl/bpp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_checker
// Port-level checks for the bitplane to palette pixel block.
// ----------------------------------------------------------------------------
module bpp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input bpp_pkg::out_item_t out_item,
	input logic               pready
);
	import bpp_pkg::*;

	// a pending input request always sees a known ready
	a_in_ready_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> !$isunknown(in_ready))
		else $error("in_ready unknown");

	// a stalled pixel request holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("pixel changed while stalled");

	// a line always ends on a group boundary
	a_line_on_group: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.last_of_line |-> out_item.last_of_group)
		else $error("line end without group end");

	// a group end is followed by a pixel of a new group only after handshake
	a_group_end_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.last_of_group && !out_ready |=>
		out_item.last_of_group)
		else $error("group end dropped while stalled");

	// configuration port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind bitplane_to_palette_pixels bpp_checker u_bpp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item),
	.pready    (pready)
);
